@@ hw/rtl/min_cost_stick_cutting_dp_macros.svh @@
// Assertion helpers for the stick cutting block.
// Both forms sample on clk_i and are switched off while rst_ni is low.
`ifndef MIN_COST_STICK_CUTTING_DP_MACROS_SVH
`define MIN_COST_STICK_CUTTING_DP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mcsc_pkg.sv @@
package mcsc_pkg;

  // Fixed widths of the external fields.
  localparam int unsigned CUT_POS_BITS = 20;
  localparam int unsigned STICK_BITS   = 20;
  localparam int unsigned COST_BITS    = 26;

  // Largest cost that the result field can carry; larger costs saturate.
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

endpackage

@@ hw/rtl/mcsc_cut_if.sv @@
interface mcsc_cut_if;
  import mcsc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CUT_POS_BITS-1:0] cut_position;
  logic                    last;

  modport source (output valid, cut_position, last, input ready);
  modport sink   (input valid, cut_position, last, output ready);

endinterface

@@ hw/rtl/mcsc_res_if.sv @@
interface mcsc_res_if;
  import mcsc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [COST_BITS-1:0] total_cost;
  logic                 overflow;

  modport source (output valid, total_cost, overflow, input ready);
  modport sink   (input valid, total_cost, overflow, output ready);

endinterface

@@ hw/rtl/min_cost_stick_cutting_dp.sv @@
// Loading: one cut beat per cycle while the block is loading; the beat marked last closes the job.
// While a job of c points (valid cuts + 2) is finished, the single shared
// add-and-compare unit works through the span cost memory.
// Reset clears the control state, sets stick_length to 7 and leaves the point
// and span cost memories uncleared; there is no clearing pass.
`include "min_cost_stick_cutting_dp_macros.svh"

module min_cost_stick_cutting_dp #(
  parameter int unsigned POINT_SLOTS   = 64,
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            stick_length_we_i,
  input  logic [mcsc_pkg::STICK_BITS-1:0] stick_length_i,
  mcsc_cut_if.sink                        cut_i,
  mcsc_res_if.source                      res_o
);
  import mcsc_pkg::*;

  // Index width of one point, cost width of one span, and the width in which
  // the final cost is compared against the saturation limit.
  localparam int unsigned IW = $clog2(POINT_SLOTS);
  localparam int unsigned PW = POSITION_BITS;
  localparam int unsigned CW = POSITION_BITS + IW;
  localparam int unsigned RW = (CW > COST_BITS) ? CW : COST_BITS;
  localparam int unsigned TW = 2 * IW;
  localparam int unsigned TABLE_DEPTH = 2 ** TW;
  // Two slots are kept back for the end points of the stick.
  localparam logic [IW-1:0] STORE_MAX = IW'(POINT_SLOTS - 2);

  // The sequencer walks through loading, ranking the stored cuts into sorted
  // order, seeding the adjacent spans, the span recurrence and hand-over.
  typedef enum logic [11:0] {
    S_LOAD = 12'b0000_0000_0001,
    S_SRD  = 12'b0000_0000_0010,
    S_SJ   = 12'b0000_0000_0100,
    S_SCAN = 12'b0000_0000_1000,
    S_PUT  = 12'b0000_0001_0000,
    S_END0 = 12'b0000_0010_0000,
    S_END1 = 12'b0000_0100_0000,
    S_ADJ  = 12'b0000_1000_0000,
    S_MR   = 12'b0001_0000_0000,
    S_MW   = 12'b0010_0000_0000,
    S_WR   = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Control registers.
  logic [STICK_BITS-1:0] stick_q;
  logic [IW-1:0]         cnt_q, cnt_d;     // cuts held in the point store
  logic                  ov_q, ov_d;       // a cut of this job was dropped
  logic [IW-1:0]         j_q, j_d;         // cut being ranked
  logic [IW-1:0]         k_q, k_d;         // cut being compared against
  logic [IW-1:0]         kd_q, kd_d;       // index of the word now on the read port
  logic [IW-1:0]         rank_q, rank_d;
  logic [IW-1:0]         vc_q, vc_d;       // valid cuts placed so far
  logic [IW-1:0]         l_q, l_d;
  logic [IW-1:0]         r_q, r_d;
  logic [IW-1:0]         m_q, m_d;
  logic                  first_q, first_d; // first split point of a span
  logic                  sv_q, sv_d;       // point store read in flight
  logic                  acc_v_q, acc_v_d; // span cost pair in flight
  logic                  res_v_q, res_v_d;

  // Data registers.
  logic [PW-1:0]         pj_q, pj_d;
  logic [CW-1:0]         best_q, best_d;
  logic [CW-1:0]         cost_q, cost_d;
  logic [COST_BITS-1:0]  res_cost_q, res_cost_d;
  logic                  res_ov_q, res_ov_d;

  // Memory ports.
  logic [PW-1:0] pstore_mem [POINT_SLOTS];
  logic [PW-1:0] ps_rd_q;
  logic          ps_we, ps_re;
  logic [IW-1:0] ps_raddr;

  logic [PW-1:0] pts_mem [POINT_SLOTS];
  logic [PW-1:0] ptl_q, ptr_q;
  logic          pt_we, pt_re;
  logic [IW-1:0] pt_waddr;
  logic [PW-1:0] pt_wdata;

  logic [CW-1:0] span_mem [TABLE_DEPTH];
  logic [CW-1:0] spa_q, spb_q;
  logic          sp_we, sp_re;
  logic [TW-1:0] sp_waddr, sp_raddr_a, sp_raddr_b;
  logic [CW-1:0] sp_wdata;

  // Datapath.
  logic [PW-1:0] pos_in;
  logic [PW-1:0] stick_pw;
  logic          rd_ok;
  logic          rd_before_j;
  logic [CW-1:0] pair_sum;
  logic [CW-1:0] span_len;
  logic [CW-1:0] span_cost;
  logic [RW-1:0] cost_ext;
  logic [COST_BITS-1:0] cost_sat;
  logic          cut_acc;

  // Positions are taken at the configured width; extra upper bits drop away.
  assign pos_in   = PW'(cut_i.cut_position);
  assign stick_pw = PW'(stick_q);

  // A stored position counts as a cut only strictly inside the stick.
  assign rd_ok = (ps_rd_q != '0) && (ps_rd_q < stick_pw);
  // Ties are broken by arrival order so that equal cuts get distinct ranks.
  assign rd_before_j = rd_ok &&
                       ((ps_rd_q < pj_q) || ((ps_rd_q == pj_q) && (kd_q < j_q)));

  // Costs are bounded by (points - 1) times the stick length, so the sums
  // below never exceed CW bits.
  assign pair_sum  = spa_q + spb_q;
  assign span_len  = CW'(ptr_q - ptl_q);
  assign span_cost = best_q + span_len;

  assign cost_ext = RW'(cost_q);
  assign cost_sat = (cost_ext > RW'(COST_MAX)) ? COST_MAX : cost_ext[COST_BITS-1:0];

  assign cut_i.ready = (state_q == S_LOAD);
  assign cut_acc     = cut_i.valid && cut_i.ready;

  assign res_o.valid      = res_v_q;
  assign res_o.total_cost = res_cost_q;
  assign res_o.overflow   = res_ov_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ov_d       = ov_q;
    j_d        = j_q;
    k_d        = k_q;
    kd_d       = kd_q;
    rank_d     = rank_q;
    vc_d       = vc_q;
    l_d        = l_q;
    r_d        = r_q;
    m_d        = m_q;
    first_d    = first_q;
    sv_d       = sv_q;
    acc_v_d    = 1'b0;
    res_v_d    = res_v_q;
    pj_d       = pj_q;
    best_d     = best_q;
    cost_d     = cost_q;
    res_cost_d = res_cost_q;
    res_ov_d   = res_ov_q;

    ps_we      = 1'b0;
    ps_re      = 1'b0;
    ps_raddr   = j_q;
    pt_we      = 1'b0;
    pt_re      = 1'b0;
    pt_waddr   = '0;
    pt_wdata   = '0;
    sp_we      = 1'b0;
    sp_re      = 1'b0;
    sp_waddr   = {l_q, r_q};
    sp_wdata   = '0;
    sp_raddr_a = {l_q, m_q};
    sp_raddr_b = {m_q, r_q};

    // The pair read in the previous cycle is folded into the running minimum.
    if (acc_v_q && (pair_sum < best_q)) begin
      best_d = pair_sum;
    end

    if (res_v_q && res_o.ready) begin
      res_v_d = 1'b0;
    end

    case (state_q)
      S_LOAD: begin
        if (cut_acc) begin
          if (cnt_q != STORE_MAX) begin
            ps_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ov_d = 1'b1;
          end
          if (cut_i.last) begin
            j_d     = '0;
            vc_d    = '0;
            state_d = S_SRD;
          end
        end
      end

      // Fetch the next cut to be ranked.
      S_SRD: begin
        if (j_q == cnt_q) begin
          state_d = S_END0;
        end else begin
          ps_re    = 1'b1;
          ps_raddr = j_q;
          state_d  = S_SJ;
        end
      end

      S_SJ: begin
        pj_d = ps_rd_q;
        if (rd_ok) begin
          k_d     = '0;
          rank_d  = '0;
          sv_d    = 1'b0;
          state_d = S_SCAN;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_SRD;
        end
      end

      // Count the valid cuts that sort ahead of the held one.
      S_SCAN: begin
        sv_d = 1'b0;
        if (sv_q && rd_before_j) begin
          rank_d = rank_q + 1'b1;
        end
        if (k_q != cnt_q) begin
          ps_re    = 1'b1;
          ps_raddr = k_q;
          kd_d     = k_q;
          k_d      = k_q + 1'b1;
          sv_d     = 1'b1;
        end else if (!sv_q) begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        pt_we    = 1'b1;
        pt_waddr = rank_q + 1'b1;
        pt_wdata = pj_q;
        vc_d     = vc_q + 1'b1;
        j_d      = j_q + 1'b1;
        state_d  = S_SRD;
      end

      S_END0: begin
        pt_we    = 1'b1;
        pt_waddr = '0;
        pt_wdata = '0;
        cost_d   = '0;
        state_d  = S_END1;
      end

      S_END1: begin
        pt_we    = 1'b1;
        pt_waddr = vc_q + 1'b1;
        pt_wdata = stick_pw;
        l_d      = '0;
        state_d  = S_ADJ;
      end

      // Spans between neighbouring points cost nothing.
      S_ADJ: begin
        sp_we    = 1'b1;
        sp_waddr = {l_q, IW'(l_q + 1'b1)};
        sp_wdata = '0;
        if (l_q == vc_q) begin
          if (vc_q == '0) begin
            state_d = S_DONE;
          end else begin
            l_d     = '0;
            r_d     = IW'(2);
            m_d     = IW'(1);
            first_d = 1'b1;
            state_d = S_MR;
          end
        end else begin
          l_d = l_q + 1'b1;
        end
      end

      // Issue one split point of the current span per cycle.
      S_MR: begin
        sp_re   = 1'b1;
        acc_v_d = 1'b1;
        if (first_q) begin
          pt_re   = 1'b1;
          best_d  = '1;
          first_d = 1'b0;
        end
        if (m_q == IW'(r_q - 1'b1)) begin
          state_d = S_MW;
        end else begin
          m_d = m_q + 1'b1;
        end
      end

      S_MW: begin
        state_d = S_WR;
      end

      S_WR: begin
        sp_we    = 1'b1;
        sp_waddr = {l_q, r_q};
        sp_wdata = span_cost;
        cost_d   = span_cost;
        first_d  = 1'b1;
        state_d  = S_MR;
        if (r_q == IW'(vc_q + 1'b1)) begin
          if (l_q == '0) begin
            state_d = S_DONE;
          end else begin
            r_d = IW'(r_q - l_q + 1'b1);
            l_d = '0;
          end
        end else begin
          l_d = l_q + 1'b1;
          r_d = r_q + 1'b1;
        end
        m_d = IW'(l_d + 1'b1);
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!res_v_q || res_o.ready) begin
          res_v_d    = 1'b1;
          res_cost_d = cost_sat;
          res_ov_d   = ov_q;
          cnt_d      = '0;
          ov_d       = 1'b0;
          state_d    = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      stick_q <= STICK_BITS'(7);
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      j_q     <= '0;
      k_q     <= '0;
      kd_q    <= '0;
      rank_q  <= '0;
      vc_q    <= '0;
      l_q     <= '0;
      r_q     <= '0;
      m_q     <= '0;
      first_q <= 1'b0;
      sv_q    <= 1'b0;
      acc_v_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (stick_length_we_i) begin
        stick_q <= stick_length_i;
      end
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      j_q     <= j_d;
      k_q     <= k_d;
      kd_q    <= kd_d;
      rank_q  <= rank_d;
      vc_q    <= vc_d;
      l_q     <= l_d;
      r_q     <= r_d;
      m_q     <= m_d;
      first_q <= first_d;
      sv_q    <= sv_d;
      acc_v_q <= acc_v_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pj_q       <= pj_d;
    best_q     <= best_d;
    cost_q     <= cost_d;
    res_cost_q <= res_cost_d;
    res_ov_q   <= res_ov_d;
  end

  // Point store: cuts in arrival order.
  always_ff @(posedge clk_i) begin
    if (ps_we) begin
      pstore_mem[cnt_q] <= pos_in;
    end
    if (ps_re) begin
      ps_rd_q <= pstore_mem[ps_raddr];
    end
  end

  // Sorted point list: both ends of a span are read together.
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pts_mem[pt_waddr] <= pt_wdata;
    end
    if (pt_re) begin
      ptl_q <= pts_mem[l_q];
      ptr_q <= pts_mem[r_q];
    end
  end

  // Span cost table, addressed by left and right point index.
  always_ff @(posedge clk_i) begin
    if (sp_we) begin
      span_mem[sp_waddr] <= sp_wdata;
    end
    if (sp_re) begin
      spa_q <= span_mem[sp_raddr_a];
      spb_q <= span_mem[sp_raddr_b];
    end
  end

  `MCSC_ASSERT_NEXT(a_last_closes_load, cut_acc && cut_i.last, !cut_i.ready, "last beat did not close loading")
  `MCSC_ASSERT_NOW(a_store_bound, 1'b1, cnt_q <= STORE_MAX, "point store count beyond capacity")
  `MCSC_ASSERT_NOW(a_span_wide, state_q == S_WR, r_q > IW'(l_q + 1'b1), "span write on an adjacent pair")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import mcsc_pkg::*;

  // The block under test is built with its default sizes, so the predictor
  // uses the same number of point slots.
  localparam int unsigned SLOTS          = 64;
  localparam int unsigned CUT_ROOM       = SLOTS - 2;
  localparam int unsigned POS_TOP        = (1 << CUT_POS_BITS) - 1;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned LONG_HOLD      = 3000;
  localparam int unsigned RANDOM_ITEMS   = 1100;
  // After its last beat, a full job of 64 points is solved with no beat on
  // either side. The limit leaves margin for that solving, plus a long stall.
  localparam int unsigned WATCHDOG_LIMIT = 250000;

  typedef struct packed {
    logic [COST_BITS-1:0] total_cost;
    logic                 overflow;
  } job_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  stick_length_we;
  logic [STICK_BITS-1:0] stick_length_val;

  mcsc_cut_if cut_if ();
  mcsc_res_if res_if ();

  min_cost_stick_cutting_dp u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .stick_length_we_i (stick_length_we),
    .stick_length_i    (stick_length_val),
    .cut_i             (cut_if),
    .res_o             (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: the stick length as the block should hold it, the cuts
  // of the job in progress kept in ascending order, and whether any cut of
  // this job was dropped because the store was full.
  logic [STICK_BITS-1:0]   stick_len;
  logic [CUT_POS_BITS-1:0] job_cuts[$];
  logic                    job_dropped;
  job_result_t             pending_job_results[$];

  // Shared controls and bookkeeping.
  bit          idle_on;
  int unsigned hold_request;
  int unsigned error_count;
  int unsigned cut_beats;
  int unsigned jobs_sent;
  int unsigned overflow_jobs;
  int unsigned results_seen;
  int unsigned length_writes;

  task automatic flag_error(input string what);
    if (error_count < 50) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
    error_count++;
  endtask

  // Gap lengths: mostly none or short ones, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(3, 1);
    end
    if (r < 98) begin
      return $urandom_range(15, 4);
    end
    return $urandom_range(120, 30);
  endfunction

  // Minimum cutting cost of the current job. The point list is 0, every
  // stored cut strictly inside the stick, then the stick length. Spans are
  // filled shortest first; a span between neighbouring points costs nothing.
  function automatic logic [COST_BITS-1:0] cheapest_cut_cost();
    longint unsigned   span [SLOTS][SLOTS];
    logic [STICK_BITS-1:0] pts[$];
    longint unsigned   best;
    longint unsigned   v;
    int                c;
    int                r;
    pts.push_back('0);
    foreach (job_cuts[i]) begin
      if (job_cuts[i] != 0 && job_cuts[i] < stick_len) begin
        pts.push_back(job_cuts[i]);
      end
    end
    pts.push_back(stick_len);
    c = pts.size();
    for (int l = 0; l + 1 < c; l++) begin
      span[l][l + 1] = 0;
    end
    for (int w = 2; w < c; w++) begin
      for (int l = 0; l + w < c; l++) begin
        r    = l + w;
        best = '1;
        for (int m = l + 1; m < r; m++) begin
          v = span[l][m] + span[m][r];
          if (v < best) begin
            best = v;
          end
        end
        span[l][r] = best + (longint'(pts[r]) - longint'(pts[l]));
      end
    end
    if (c < 3) begin
      return '0;
    end
    if (span[0][c - 1] > COST_MAX) begin
      return COST_MAX;
    end
    return span[0][c - 1][COST_BITS-1:0];
  endfunction

  // Book one accepted cut beat into the predictor. The store keeps two slots
  // for the end points, so only CUT_ROOM cuts fit; later ones are dropped.
  task automatic book_cut(input logic [CUT_POS_BITS-1:0] pos, input logic is_last);
    int idx;
    job_result_t res;
    cut_beats++;
    if (job_cuts.size() >= CUT_ROOM) begin
      job_dropped = 1'b1;
    end else begin
      idx = job_cuts.size();
      foreach (job_cuts[i]) begin
        if (job_cuts[i] > pos && idx == job_cuts.size()) begin
          idx = i;
        end
      end
      job_cuts.insert(idx, pos);
    end
    if (is_last) begin
      res.total_cost = cheapest_cut_cost();
      res.overflow   = job_dropped;
      pending_job_results.push_back(res);
      jobs_sent++;
      if (job_dropped) begin
        overflow_jobs++;
      end
      job_cuts.delete();
      job_dropped = 1'b0;
    end
  endtask

  // Offer one cut beat and wait for it to be taken. Must be entered at a
  // rising edge. With no gap drawn, valid stays high for the next beat.
  task automatic send_cut(input logic [CUT_POS_BITS-1:0] pos, input logic is_last);
    int unsigned gap;
    cut_if.valid        <= 1'b1;
    cut_if.cut_position <= pos;
    cut_if.last         <= is_last;
    do @(posedge clk_i); while (cut_if.ready !== 1'b1);
    book_cut(pos, is_last);
    gap = idle_len();
    if (gap != 0) begin
      cut_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering, wait for every outstanding result, then let the block
  // settle before anything else is changed.
  task automatic drain_results();
    cut_if.valid <= 1'b0;
    while (pending_job_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_stick_length(input logic [STICK_BITS-1:0] len);
    stick_length_we  <= 1'b1;
    stick_length_val <= len;
    @(posedge clk_i);
    stick_length_we  <= 1'b0;
    stick_len        = len;
    length_writes++;
  endtask

  task automatic check_result_beat();
    job_result_t want;
    if (pending_job_results.size() == 0) begin
      flag_error($sformatf("result beat with no job outstanding: cost %0d overflow %0b",
                           res_if.total_cost, res_if.overflow));
      return;
    end
    want = pending_job_results.pop_front();
    results_seen++;
    if (res_if.total_cost !== want.total_cost) begin
      flag_error($sformatf("total_cost %0d, expected %0d", res_if.total_cost,
                           want.total_cost));
    end
    if (res_if.overflow !== want.overflow) begin
      flag_error($sformatf("overflow %0b, expected %0b", res_if.overflow, want.overflow));
    end
  endtask

  // Result side: checks every beat at the edge where it is taken and drives
  // ready. A hold request from a test keeps ready low until the requested stall has counted down.
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        check_result_beat();
      end
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else if (stall == 0 && idle_on && $urandom_range(99) < 25) begin
        stall = idle_len();
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Ends the run if neither side moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((cut_if.valid === 1'b1 && cut_if.ready === 1'b1) ||
          (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog expired after %0d cycles without a beat", quiet);
    $display("Some tests failed");
    $finish;
  end

  // Stimulus helpers for the random part.
  function automatic logic [STICK_BITS-1:0] random_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) begin
      return STICK_BITS'(POS_TOP);
    end
    if (r < 15) begin
      return STICK_BITS'(1);
    end
    if (r < 18) begin
      return '0;
    end
    if (r < 48) begin
      return STICK_BITS'($urandom_range(64, 2));
    end
    return STICK_BITS'($urandom_range(POS_TOP, 1));
  endfunction

  // Mostly cuts inside the stick, with repeats, zeros, cuts on or beyond the
  // right end, and fully random words so that every position bit toggles.
  function automatic logic [CUT_POS_BITS-1:0] random_position();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10 && job_cuts.size() != 0) begin
      return job_cuts[$urandom_range(job_cuts.size() - 1)];
    end
    if (r < 18) begin
      return '0;
    end
    if (r < 26) begin
      return CUT_POS_BITS'($urandom_range(POS_TOP, stick_len));
    end
    if (r < 40 || stick_len < 2) begin
      return CUT_POS_BITS'($urandom());
    end
    return CUT_POS_BITS'($urandom_range(stick_len - 1, 1));
  endfunction

  // Job sizes: mostly a handful of cuts, sometimes 7 to 24, and rarely
  // enough to fill the store or run past it. Large jobs are slow to solve.
  function automatic int random_job_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      return int'($urandom_range(6, 1));
    end
    if (r < 96) begin
      return int'($urandom_range(24, 7));
    end
    return int'($urandom_range(70, 40));
  endfunction

  // The reset length of 7 is checked with the classic four-cut example.
  task automatic test_reset_length();
    send_cut(20'd1, 1'b0);
    send_cut(20'd3, 1'b0);
    send_cut(20'd4, 1'b0);
    send_cut(20'd5, 1'b1);
    drain_results();
  endtask

  // A job with no cuts sends a single beat at position 0.
  task automatic test_zero_cut_job();
    send_cut('0, 1'b1);
    drain_results();
  endtask

  // Cuts at 0, on the right end or beyond it cost nothing; repeated cuts
  // are each charged.
  task automatic test_outside_and_repeats();
    write_stick_length(20'd10);
    send_cut('0, 1'b0);
    send_cut(20'd10, 1'b0);
    send_cut(20'd11, 1'b0);
    send_cut(CUT_POS_BITS'(POS_TOP), 1'b0);
    send_cut(20'd5, 1'b1);
    send_cut(20'd4, 1'b0);
    send_cut(20'd4, 1'b0);
    send_cut(20'd4, 1'b1);
    drain_results();
  endtask

  // A stick of zero length ignores every cut.
  task automatic test_zero_length();
    write_stick_length('0);
    send_cut(20'd3, 1'b0);
    send_cut(CUT_POS_BITS'(POS_TOP), 1'b0);
    send_cut(20'd1, 1'b1);
    drain_results();
  endtask

  // The longest stick with cuts at its edges and alternating bit patterns.
  task automatic test_extremes();
    write_stick_length(STICK_BITS'(POS_TOP));
    send_cut(CUT_POS_BITS'(POS_TOP - 1), 1'b0);
    send_cut(20'd1, 1'b0);
    send_cut(20'h80000, 1'b1);
    send_cut(20'haaaaa, 1'b0);
    send_cut(20'h55555, 1'b1);
    drain_results();
  endtask

  // The length in force at the last beat decides which cuts count, so a
  // cut loaded under the old length can fall outside the new one.
  task automatic test_length_change_in_job();
    write_stick_length(20'd100);
    drain_results();
    send_cut(20'd30, 1'b0);
    send_cut(20'd60, 1'b0);
    drain_results();
    write_stick_length(20'd50);
    send_cut(20'd20, 1'b1);
    drain_results();
  endtask

  // Two more cuts than the store holds: the result must flag the drop, and
  // the following job must start clean again.
  task automatic test_store_full();
    idle_on = 1'b0;
    write_stick_length(STICK_BITS'(POS_TOP));
    for (int i = 0; i < int'(CUT_ROOM) + 2; i++) begin
      send_cut(CUT_POS_BITS'($urandom()), i == int'(CUT_ROOM) + 1);
    end
    send_cut(20'd12345, 1'b0);
    send_cut(20'd777, 1'b1);
    drain_results();
    idle_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while short jobs keep coming,
  // so the block fills up and stops taking cut beats. The sender then waits
  // for every result.
  task automatic test_result_backpressure();
    idle_on = 1'b0;
    write_stick_length(20'd1000);
    hold_request = LONG_HOLD;
    for (int j = 0; j < 6; j++) begin
      send_cut(CUT_POS_BITS'($urandom_range(999, 1)), 1'b0);
      send_cut(CUT_POS_BITS'($urandom_range(999, 1)), 1'b0);
      send_cut(CUT_POS_BITS'($urandom_range(999, 1)), 1'b1);
    end
    idle_on = 1'b1;
    drain_results();
  endtask

  task automatic test_random_jobs();
    int items;
    int job_len;
    items = 0;
    while (items < int'(RANDOM_ITEMS)) begin
      if ($urandom_range(9) == 0) begin
        drain_results();
        write_stick_length(random_length());
      end
      // About one job in five runs with no gaps on either side.
      idle_on = ($urandom_range(4) != 0);
      job_len = random_job_len();
      for (int i = 0; i < job_len; i++) begin
        send_cut(random_position(), i == job_len - 1);
      end
      items += job_len;
    end
    idle_on = 1'b1;
    drain_results();
  endtask

  initial begin
    stick_len     = 20'd7;
    job_dropped   = 1'b0;
    idle_on       = 1'b1;
    hold_request  = 0;
    error_count   = 0;
    cut_beats     = 0;
    jobs_sent     = 0;
    overflow_jobs = 0;
    results_seen  = 0;
    length_writes = 0;

    rst_ni              <= 1'b0;
    cut_if.valid        <= 1'b0;
    cut_if.cut_position <= '0;
    cut_if.last         <= 1'b0;
    stick_length_we     <= 1'b0;
    stick_length_val    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_length();
    test_zero_cut_job();
    test_outside_and_repeats();
    test_zero_length();
    test_extremes();
    test_length_change_in_job();
    test_store_full();
    test_result_backpressure();
    test_random_jobs();

    $display("Run covered %0d jobs from %0d cut beats, %0d of them over capacity,",
             jobs_sent, cut_beats, overflow_jobs);
    $display("with %0d stick length writes and %0d results checked.",
             length_writes, results_seen);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/mcsc_pkg.sv
hw/rtl/mcsc_cut_if.sv
hw/rtl/mcsc_res_if.sv
hw/rtl/min_cost_stick_cutting_dp.sv
dv/testbench.sv
